// ----- rtl/pipeline_execute_alu_top_macros.svh -----
// Assertion macros for the execute ALU checker.
`ifndef PIPELINE_EXECUTE_ALU_TOP_MACROS_SVH
`define PIPELINE_EXECUTE_ALU_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, off while in reset.
`define PEA_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked after a fixed delay given by argument n.
`define PEA_ASSERT_DLY(name, ante, n, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

// ----- rtl/pea_pkg.sv -----
`default_nettype none

package pea_pkg;

    // Opcode / func codes
    localparam logic [5:0] OP_SPECIAL   = 6'd0;
    localparam logic [5:0] OP_SLTI      = 6'd24;
    localparam logic [5:0] OP_LUI       = 6'd39;
    localparam logic [5:0] OP_ZEXT_LO   = 6'd20;
    localparam logic [5:0] OP_ZEXT_HI   = 6'd22;
    localparam logic [5:0] FN_ALU_MIN   = 6'd16;
    localparam logic [5:0] FN_SLT       = 6'd24;
    localparam logic [5:0] FN_SLTU      = 6'd25;
    localparam logic [5:0] FN_SHIFT_MIN = 6'd37;

    // func[5:3] groups for shifts
    localparam logic [2:0] SH_GRP_SHAMT = 3'd4;
    localparam logic [2:0] SH_GRP_REG   = 3'd5;

    // 3-bit basic op codes
    localparam logic [2:0] BOP_ADD0 = 3'd0;
    localparam logic [2:0] BOP_ADD1 = 3'd1;
    localparam logic [2:0] BOP_SUB0 = 3'd2;
    localparam logic [2:0] BOP_SUB1 = 3'd3;
    localparam logic [2:0] BOP_AND  = 3'd4;
    localparam logic [2:0] BOP_OR   = 3'd5;
    localparam logic [2:0] BOP_XOR  = 3'd6;
    localparam logic [2:0] BOP_NOR  = 3'd7;

    // shift kinds in func[2:0]
    localparam logic [2:0] SH_SLL = 3'd5;
    localparam logic [2:0] SH_SRL = 3'd6;
    localparam logic [2:0] SH_SRA = 3'd7;

    typedef enum logic [3:0] {
        K_ADD,
        K_SUB,
        K_AND,
        K_OR,
        K_XOR,
        K_NOR,
        K_SLT,
        K_SLTU,
        K_SLL,
        K_SRL,
        K_SRA,
        K_LUI,
        K_ZERO
    } pea_kind_t;

    typedef struct packed {
        logic [31:0] instruction;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic [31:0] next_pc;
    } pea_req_t;

    typedef struct packed {
        logic [31:0] result;
        logic        branch_cond;
    } pea_rsp_t;

    // Decoded word leaving the first stage
    typedef struct packed {
        pea_kind_t   kind;
        logic [31:0] lhs;
        logic [31:0] rhs;
        logic [4:0]  amt;
        logic        cond;
    } pea_dec_t;

    // Partial results leaving the second stage
    typedef struct packed {
        pea_kind_t   kind;
        logic [31:0] sum;
        logic [31:0] logic_res;
        logic [31:0] shift_res;
        logic        less;
        logic        cond;
    } pea_exe_t;

endpackage

`default_nettype wire

// ----- rtl/pipeline_execute_alu_top.sv -----
`default_nettype none

// Execute-stage integer ALU. One word may be issued with start in every
// clock cycle; busy is tied low because nothing inside ever blocks. Each
// word comes back on response, marked by a one-cycle done strobe, in issue
// order. The three register stages are decode (immediate and operand
// select), execute (adder, compares, logic, barrel shifter) and result
// select; the stage count sets the latency. The receiver cannot stall, so
// response is valid only in the cycle done is high and must be captured
// then.
module pipeline_execute_alu_top (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire pea_pkg::pea_req_t request,
    output logic                  done,
    output pea_pkg::pea_rsp_t     response
);

    import pea_pkg::*;

    // ------------------------------------------------------------------
    // Stage 1: decode
    // ------------------------------------------------------------------
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [15:0] lo;
    logic [31:0] imm;
    logic        is_alu;
    logic        is_mem;
    pea_dec_t    dec_next;
    pea_dec_t    dec_reg;
    logic        v1_reg;

    assign op = request.instruction[31:26];
    assign fn = request.instruction[5:0];
    assign lo = request.instruction[15:0];

    // Logical immediates (andi/ori/xori rows) are zero-filled.
    assign imm = (op >= OP_ZEXT_LO && op <= OP_ZEXT_HI) ? {16'h0000, lo}
                                                        : {{16{lo[15]}}, lo};

    assign is_alu = (op == OP_SPECIAL && fn >= FN_ALU_MIN)
                 || (op[5:4] == 2'b01) || (op == OP_LUI);
    assign is_mem = (op[5:4] == 2'b10);

    always_comb
    begin
        dec_next.kind = K_ADD;
        dec_next.lhs  = request.operand_a;
        dec_next.rhs  = imm;
        dec_next.amt  = request.operand_a[4:0];
        dec_next.cond = 1'b0;
        if (is_alu)
        begin
            priority if (op == OP_SPECIAL && fn >= FN_SHIFT_MIN)
            begin
                dec_next.rhs = request.operand_b;
                dec_next.amt = (fn[5:3] == SH_GRP_SHAMT) ? request.instruction[10:6]
                                                         : request.operand_a[4:0];
                if (fn[5:3] != SH_GRP_SHAMT && fn[5:3] != SH_GRP_REG)
                    dec_next.kind = K_ZERO;
                else
                begin
                    unique case (fn[2:0])
                        SH_SLL:  dec_next.kind = K_SLL;
                        SH_SRL:  dec_next.kind = K_SRL;
                        SH_SRA:  dec_next.kind = K_SRA;
                        default: dec_next.kind = K_ZERO;
                    endcase
                end
            end
            else if (op == OP_SPECIAL && fn == FN_SLT)
            begin
                dec_next.kind = K_SLT;
                dec_next.rhs  = request.operand_b;
            end
            else if (op == OP_SLTI)
                dec_next.kind = K_SLT;
            else if (op == OP_SPECIAL && fn == FN_SLTU)
            begin
                dec_next.kind = K_SLTU;
                dec_next.rhs  = request.operand_b;
            end
            else if (op == OP_LUI)
            begin
                dec_next.kind = K_LUI;
                dec_next.rhs  = {lo, 16'h0000};
            end
            else
            begin
                // R-type takes func and rt, I-type takes opcode and imm
                if (op == OP_SPECIAL)
                    dec_next.rhs = request.operand_b;
                unique case ((op == OP_SPECIAL) ? fn[2:0] : op[2:0])
                    BOP_ADD0, BOP_ADD1: dec_next.kind = K_ADD;
                    BOP_SUB0, BOP_SUB1: dec_next.kind = K_SUB;
                    BOP_AND:            dec_next.kind = K_AND;
                    BOP_OR:             dec_next.kind = K_OR;
                    BOP_XOR:            dec_next.kind = K_XOR;
                    BOP_NOR:            dec_next.kind = K_NOR;
                    default:            dec_next.kind = K_ADD;
                endcase
            end
        end
        else if (!is_mem)
        begin
            // Branch path (also reserved opcodes): target and zero test.
            dec_next.lhs  = request.next_pc;
            dec_next.cond = (request.operand_a == 32'h0000_0000);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: execute
    // ------------------------------------------------------------------
    logic        do_sub;
    logic [31:0] add_rhs;
    pea_exe_t    exe_next;
    pea_exe_t    exe_reg;
    logic        v2_reg;

    assign do_sub  = (dec_reg.kind == K_SUB);
    assign add_rhs = do_sub ? ~dec_reg.rhs : dec_reg.rhs;

    always_comb
    begin
        exe_next.kind = dec_reg.kind;
        exe_next.cond = dec_reg.cond;
        exe_next.sum  = dec_reg.lhs + add_rhs + {31'd0, do_sub};

        unique case (dec_reg.kind)
            K_AND:   exe_next.logic_res = dec_reg.lhs & dec_reg.rhs;
            K_OR:    exe_next.logic_res = dec_reg.lhs | dec_reg.rhs;
            K_XOR:   exe_next.logic_res = dec_reg.lhs ^ dec_reg.rhs;
            default: exe_next.logic_res = ~(dec_reg.lhs | dec_reg.rhs);
        endcase

        if (dec_reg.kind == K_SLTU)
            exe_next.less = (dec_reg.lhs < dec_reg.rhs);
        else
            exe_next.less = ($signed(dec_reg.lhs) < $signed(dec_reg.rhs));

        unique case (dec_reg.kind)
            K_SLL:   exe_next.shift_res = dec_reg.rhs << dec_reg.amt;
            K_SRL:   exe_next.shift_res = dec_reg.rhs >> dec_reg.amt;
            K_SRA:   exe_next.shift_res = 32'($signed(dec_reg.rhs) >>> dec_reg.amt);
            K_LUI:   exe_next.shift_res = dec_reg.rhs;
            default: exe_next.shift_res = 32'h0000_0000;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 3: result select
    // ------------------------------------------------------------------
    pea_rsp_t rsp_next;
    pea_rsp_t rsp_reg;
    logic     v3_reg;

    always_comb
    begin
        rsp_next.branch_cond = exe_reg.cond;
        unique case (exe_reg.kind)
            K_ADD, K_SUB:               rsp_next.result = exe_reg.sum;
            K_AND, K_OR, K_XOR, K_NOR:  rsp_next.result = exe_reg.logic_res;
            K_SLT, K_SLTU:              rsp_next.result = {31'd0, exe_reg.less};
            default:                    rsp_next.result = exe_reg.shift_res;
        endcase
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        dec_reg <= dec_next;
        exe_reg <= exe_next;
        rsp_reg <= rsp_next;
    end

    assign busy     = 1'b0;
    assign done     = v3_reg;
    assign response = rsp_reg;

endmodule

`default_nettype wire

// ----- rtl/pea_checker.sv -----
`default_nettype none

`include "pipeline_execute_alu_top_macros.svh"

module pea_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire pea_pkg::pea_req_t request,
    input wire logic              done,
    input wire pea_pkg::pea_rsp_t response
);

    import pea_pkg::*;

    // Every issued word gets a done, and every done has an issued word
    `PEA_ASSERT_DLY(a_latency, start && !busy, 3, done, "word issued but no done 3 cycles later")
    `PEA_ASSERT_IMP(a_no_orphan, done, $past(start, 3), "done without a word issued 3 cycles before")

    // Branch condition only when rs was zero
    `PEA_ASSERT_IMP(a_cond_zero, done && response.branch_cond,
        $past(request.operand_a, 3) == 32'h0000_0000, "branch_cond set with nonzero rs")

    // LUI places the immediate in the upper half
    `PEA_ASSERT_IMP(a_lui, done && $past(request.instruction[31:26], 3) == OP_LUI,
        response.result[31:16] == $past(request.instruction[15:0], 3)
        && response.result[15:0] == 16'h0000, "LUI result wrong")

endmodule

bind pipeline_execute_alu_top pea_checker u_pea_checker (.*);

`default_nettype wire
